>>> rtl/core/rpwd_pkg.sv
// ----------------------------------------------------------------------------
// rpwd_pkg
// shared widths, codes and control types of the run-length palette decoder
// ----------------------------------------------------------------------------
package rpwd_pkg;

  localparam int PIX_W     = 16;
  localparam int CNT_W     = 20;
  localparam int LEN_W     = 13;
  localparam int COL_W     = 12;
  localparam int IDX_W     = 4;
  localparam int BYTE_W    = 8;
  localparam int RUN_W     = 5;
  localparam int PAL_DEPTH = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 20;
  localparam int IN_DATA_W = 32;

  localparam logic [LEN_W-1:0] MAX_ROW = LEN_W'(4096);
  localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_SKIP = 2'd0,
    REG_ROW_SKIP   = 2'd1,
    REG_ROW_LENGTH = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_PALETTE = 1'b0,
    CMD_DATA    = 1'b1
  } cmd_t;

  typedef struct packed {
    logic load;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rem_zero;
  } dp_stat_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    if (len == '0) begin
      res = LEN_W'(1);
    end else if (len > MAX_ROW) begin
      res = MAX_ROW;
    end else begin
      res = len;
    end
    return res;
  endfunction

endpackage

>>> rtl/core/rle_palette_window_decoder.sv
// ----------------------------------------------------------------------------
// rle_palette_window_decoder
// run-length 4-bit palette decoder with start and per-row window clipping
// a palette write is stored when accepted; a data byte loads the run counter
//   and colour register, then the stepper registers its first pixel when
//   nothing is skipped and the output slot is free; one request at a time,
//   the single pixel stepper gives one pixel or drops one skipped span per step
// sync active-low reset clears counters, config to defaults; palette is kept
// ----------------------------------------------------------------------------
module rle_palette_window_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rpwd_pkg::IN_DATA_W-1:0] in_tdata,  // palette_index, palette_value, data_byte
  input  logic                           in_tuser,  // cmd
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rpwd_pkg::PIX_W-1:0]     out_tdata, // pixel
  output logic                           out_tuser, // row_end
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [rpwd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpwd_pkg::CFG_W-1:0]     cfg_wdata
);
  import rpwd_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rpwd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rpwd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_cmd           (in_tuser),
    .in_palette_index (in_tdata[IDX_W-1:0]),
    .in_palette_value (in_tdata[IDX_W+PIX_W-1:IDX_W]),
    .in_data_byte     (in_tdata[IDX_W+PIX_W+BYTE_W-1:IDX_W+PIX_W]),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_pixel        (out_tdata),
    .out_row_end      (out_tuser),
    .out_last         (out_tlast)
  );

endmodule

>>> rtl/core/rpwd_ctrl.sv
// ----------------------------------------------------------------------------
// rpwd_ctrl
// sequencer: takes one request at a time and, for a data byte, steps the
// datapath until the run is used up
// ----------------------------------------------------------------------------
module rpwd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_cmd,
  output logic                in_tready,
  input  rpwd_pkg::dp_stat_t  stat,
  output rpwd_pkg::ctrl_cmd_t cmd
);
  import rpwd_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state_r;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    cmd      = '0;
    cmd.load = accept;
    cmd.step = (state_r == ST_RUN) & ~stat.rem_zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept && (in_cmd == CMD_DATA)) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (stat.rem_zero) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == ST_IDLE)
    else $error("load outside idle");

  a_data_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && in_cmd == CMD_DATA) |=> state_r == ST_RUN)
    else $error("data byte did not start a run");

  a_run_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && stat.rem_zero) |=> state_r == ST_IDLE)
    else $error("run did not finish");

endmodule

>>> rtl/core/rpwd_dp.sv
// ----------------------------------------------------------------------------
// rpwd_dp
// datapath: config registers, palette, skip, column and run counters, result
// register
// ----------------------------------------------------------------------------
module rpwd_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rpwd_pkg::ctrl_cmd_t              cmd,
  output rpwd_pkg::dp_stat_t               stat,
  input  logic                             in_cmd,
  input  logic [rpwd_pkg::IDX_W-1:0]       in_palette_index,
  input  logic [rpwd_pkg::PIX_W-1:0]       in_palette_value,
  input  logic [rpwd_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                             cfg_we,
  input  logic [rpwd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rpwd_pkg::CFG_W-1:0]       cfg_wdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rpwd_pkg::PIX_W-1:0]       out_pixel,
  output logic                             out_row_end,
  output logic                             out_last
);
  import rpwd_pkg::*;

  logic [CNT_W-1:0] start_skip_r;
  logic [CNT_W-1:0] row_skip_r;
  logic [LEN_W-1:0] row_length_r;

  logic [PIX_W-1:0] palette_mem [PAL_DEPTH];
  logic [PIX_W-1:0] color_r;

  logic [CNT_W-1:0] skip_left_r, skip_left_nxt;
  logic [COL_W-1:0] column_r, column_nxt;
  logic [RUN_W-1:0] remaining_r, remaining_nxt;
  logic             begun_r, begun_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] pixel_r;
  logic             row_end_r, row_end_nxt;
  logic             last_r, last_nxt;

  logic             slot_free;
  logic             emit;
  logic [CNT_W-1:0] rem_ext;
  logic [LEN_W-1:0] col_inc;
  logic             row_done;
  logic [RUN_W-1:0] rem_dec;
  logic [CNT_W-1:0] skip_after;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_skip_r <= '0;
      row_skip_r   <= '0;
      row_length_r <= LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_SKIP: start_skip_r <= cfg_wdata;
        REG_ROW_SKIP:   row_skip_r   <= cfg_wdata;
        REG_ROW_LENGTH: row_length_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // palette
  always_ff @(posedge clk) begin
    if (cmd.load && (in_cmd == CMD_PALETTE)) begin
      palette_mem[in_palette_index] <= in_palette_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (in_cmd == CMD_DATA)) begin
      color_r <= palette_mem[in_data_byte[IDX_W-1:0]];
    end
  end

  assign slot_free = ~out_valid_r | out_tready;
  assign rem_ext   = CNT_W'(remaining_r);
  assign emit      = cmd.step & (skip_left_r == '0) & slot_free;
  assign col_inc   = LEN_W'(column_r) + LEN_W'(1);
  assign row_done  = col_inc >= eff_len(row_length_r);
  assign rem_dec   = remaining_r - RUN_W'(1);
  assign skip_after = row_done ? row_skip_r : '0;

  always_comb begin
    skip_left_nxt = skip_left_r;
    column_nxt    = column_r;
    remaining_nxt = remaining_r;
    begun_nxt     = begun_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    row_end_nxt   = row_end_r;
    last_nxt      = last_r;

    if (cmd.load && (in_cmd == CMD_DATA)) begin
      remaining_nxt = RUN_W'(in_data_byte[BYTE_W-1:IDX_W]) + RUN_W'(1);
      begun_nxt     = 1'b1;
      if (!begun_r) begin
        skip_left_nxt = start_skip_r;
      end
    end else if (cmd.step && (skip_left_r != '0)) begin
      // drop as much of the run as the skip allows in one go
      if (skip_left_r >= rem_ext) begin
        skip_left_nxt = skip_left_r - rem_ext;
        remaining_nxt = '0;
      end else begin
        remaining_nxt = remaining_r - skip_left_r[RUN_W-1:0];
        skip_left_nxt = '0;
      end
    end else if (emit) begin
      remaining_nxt = rem_dec;
      skip_left_nxt = skip_after;
      column_nxt    = row_done ? '0 : col_inc[COL_W-1:0];
      out_valid_nxt = 1'b1;
      row_end_nxt   = row_done;
      last_nxt      = CNT_W'(rem_dec) <= skip_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_left_r <= '0;
      column_r    <= '0;
      remaining_r <= '0;
      begun_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      skip_left_r <= skip_left_nxt;
      column_r    <= column_nxt;
      remaining_r <= remaining_nxt;
      begun_r     <= begun_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_end_r <= row_end_nxt;
    last_r    <= last_nxt;
    if (emit) begin
      pixel_r <= color_r;
    end
  end

  assign stat.rem_zero = (remaining_r == '0);
  assign out_tvalid    = out_valid_r;
  assign out_pixel     = pixel_r;
  assign out_row_end   = row_end_r;
  assign out_last      = last_r;

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    remaining_r <= RUN_MAX)
    else $error("run counter out of range");

  a_load_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && in_cmd == CMD_DATA) |=> remaining_r != '0)
    else $error("data byte loaded an empty run");

  a_row_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && row_done) |=> (skip_left_r == $past(row_skip_r)) && (column_r == '0))
    else $error("row end did not reload the skip");

endmodule

>>> tb/rpwd_pixel_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpwd_pixel_checker
// watches the request, pixel and register ports of the decoder, expands each
// accepted data byte into the pixels it should give and compares every pixel
// that leaves the block with the oldest one still owed
// ----------------------------------------------------------------------------
module rpwd_pixel_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [rpwd_pkg::IN_DATA_W-1:0] in_tdata,  // palette_index, palette_value, data_byte
  input  logic                           in_tuser,  // cmd
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [rpwd_pkg::PIX_W-1:0]     out_tdata, // pixel
  input  logic                           out_tuser, // row_end
  input  logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [rpwd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpwd_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             mismatch_cnt,
  output int                             pending_cnt
);
  import rpwd_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
    logic             last;
  } pixel_res_t;

  pixel_res_t       owed_pixels[$];
  logic [PIX_W-1:0] colour_lut [PAL_DEPTH];
  logic [CNT_W-1:0] start_skip_q;
  logic [CNT_W-1:0] row_skip_q;
  logic [LEN_W-1:0] row_len_q;
  logic [CNT_W-1:0] skip_left;
  logic [COL_W-1:0] column;
  logic             begun;
  int               errors = 0;

  always @(posedge clk) begin : expand
    pixel_res_t        want;
    pixel_res_t        held;
    logic              have_held;
    logic [BYTE_W-1:0] dbyte;
    logic [PIX_W-1:0]  colour;
    logic [LEN_W-1:0]  width;
    logic [LEN_W-1:0]  col_next;
    if (!rst_n) begin
      start_skip_q = '0;
      row_skip_q   = '0;
      row_len_q    = LEN_W'(1);
      skip_left    = '0;
      column       = '0;
      begun        = 1'b0;
      owed_pixels.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (owed_pixels.size() == 0) begin
          $error("pixel: expected none, actual %h", out_tdata);
          errors++;
        end else begin
          want = owed_pixels.pop_front();
          if (out_tdata !== want.pixel) begin
            $error("pixel: expected %h, actual %h", want.pixel, out_tdata);
            errors++;
          end
          if (out_tuser !== want.row_end) begin
            $error("row_end: expected %b, actual %b", want.row_end, out_tuser);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %b, actual %b", want.last, out_tlast);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_START_SKIP: start_skip_q = cfg_wdata[CNT_W-1:0];
          REG_ROW_SKIP:   row_skip_q   = cfg_wdata[CNT_W-1:0];
          REG_ROW_LENGTH: row_len_q    = cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_PALETTE) begin
          colour_lut[in_tdata[IDX_W-1:0]] = in_tdata[IDX_W +: PIX_W];
        end else begin
          dbyte     = in_tdata[IDX_W+PIX_W +: BYTE_W];
          colour    = colour_lut[dbyte[3:0]];
          have_held = 1'b0;
          held      = '0;
          if (!begun) begin
            skip_left = start_skip_q;
            begun     = 1'b1;
          end
          if (row_len_q == '0) begin
            width = LEN_W'(1);
          end else if (row_len_q > MAX_ROW) begin
            width = MAX_ROW;
          end else begin
            width = row_len_q;
          end
          for (int k = 0; k <= int'(dbyte[7:4]); k++) begin
            if (skip_left != '0) begin
              skip_left = skip_left - 1'b1;
            end else begin
              if (have_held) begin
                owed_pixels.push_back(held);
              end
              col_next      = {1'b0, column} + 1'b1;
              held.pixel    = colour;
              held.last     = 1'b0;
              held.row_end  = (col_next >= width);
              have_held     = 1'b1;
              if (col_next >= width) begin
                column    = '0;
                skip_left = row_skip_q;
              end else begin
                column = col_next[COL_W-1:0];
              end
            end
          end
          if (have_held) begin
            held.last = 1'b1;
            owed_pixels.push_back(held);
          end
        end
      end
    end
    pending_cnt  <= owed_pixels.size();
    mismatch_cnt <= errors;
  end

endmodule

>>> tb/rle_palette_window_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_palette_window_decoder_tb
// drives palette writes and compressed bytes into the window decoder through
// several window settings, with random gaps and stalls on both streams and one
// long pixel-side hold-off; the pixel checker beside the block does all the
// comparing and this module gives the verdict
// ----------------------------------------------------------------------------
module rle_palette_window_decoder_tb;
  import rpwd_pkg::*;

  localparam int SETTLE_CYCLES  = 40;
  localparam int STALL_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata;  // palette_index, palette_value, data_byte
  logic                 in_tuser;  // cmd
  logic                 out_tvalid;
  logic                 out_tready;
  logic [PIX_W-1:0]     out_tdata; // pixel
  logic                 out_tuser; // row_end
  logic                 out_tlast;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   mismatch_cnt;
  int                   pending_cnt;
  bit                   idle_on;
  bit                   stall_req;
  int                   quiet_cycles;

  rle_palette_window_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  rpwd_pixel_checker u_pixel_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatch_cnt (mismatch_cnt),
    .pending_cnt  (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // pixel side ready with short random bursts and one long hold-off
  initial begin : pixel_sink
    int hold_left;
    bit stall_done;
    hold_left  = 0;
    stall_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_req && !stall_done) begin
        stall_done = 1'b1;
        hold_left  = STALL_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold_left  = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // one request, held until the decoder takes it
  task automatic send_item(input cmd_t cmd, input logic [IDX_W-1:0] idx,
                           input logic [PIX_W-1:0] val, input logic [BYTE_W-1:0] dbyte);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_DATA_W-IDX_W-PIX_W-BYTE_W){1'b0}}, dbyte, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] start_skip,
                           input logic [CFG_W-1:0] row_skip,
                           input logic [CFG_W-1:0] row_len);
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_SKIP;
    cfg_wdata <= start_skip;
    @(posedge clk);
    cfg_index <= REG_ROW_SKIP;
    cfg_wdata <= row_skip;
    @(posedge clk);
    cfg_index <= REG_ROW_LENGTH;
    cfg_wdata <= row_len;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(input int count, input bit long_runs, input int stall_at);
    logic [BYTE_W-1:0] dbyte;
    for (int i = 0; i < count; i++) begin
      dbyte = BYTE_W'($urandom_range(0, 255));
      if (long_runs) begin
        dbyte[7:4] = 4'($urandom_range(12, 15));
      end
      if ($urandom_range(0, long_runs ? 19 : 5) == 0) begin
        send_item(CMD_PALETTE, IDX_W'($urandom), PIX_W'($urandom), dbyte);
      end else begin
        send_item(CMD_DATA, IDX_W'($urandom), PIX_W'($urandom), dbyte);
      end
      if (i == stall_at) begin
        stall_req <= 1'b1;
      end
    end
  endtask

  initial begin : stimulus
    logic [PIX_W-1:0]  edge_colours [4];
    logic [BYTE_W-1:0] edge_bytes [7];
    edge_colours = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555};
    edge_bytes   = '{8'hF3, 8'h10, 8'hFF, 8'h7A, 8'h00, 8'h0F, 8'hF1};
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_START_SKIP;
    cfg_wdata <= '0;
    idle_on   <= 1'b1;
    stall_req <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // leading skip partly covered by the first bytes, one pixel per row
    configure(CFG_W'(37), CFG_W'(0), CFG_W'(1));
    for (int i = 0; i < PAL_DEPTH; i++) begin
      send_item(CMD_PALETTE, IDX_W'(i), (i < 4) ? edge_colours[i] : PIX_W'($urandom),
                BYTE_W'($urandom));
    end
    foreach (edge_bytes[i]) begin
      send_item(CMD_DATA, IDX_W'($urandom), PIX_W'($urandom), edge_bytes[i]);
    end
    send_item(CMD_PALETTE, IDX_W'(1), 16'h8001, BYTE_W'($urandom));
    send_item(CMD_DATA, IDX_W'($urandom), PIX_W'($urandom), 8'h01);
    drain();

    // start skip is latched already, so its maximum must change nothing
    configure(CFG_W'(20'hFFFFF), CFG_W'(5), CFG_W'(7));
    random_items(80, 1'b0, 25);
    drain();

    configure(CFG_W'(0), CFG_W'(0), CFG_W'(0));
    random_items(30, 1'b0, -1);
    drain();

    configure(CFG_W'(12), CFG_W'(1), CFG_W'(4096));
    random_items(80, 1'b1, -1);
    drain();

    configure(CFG_W'(3), CFG_W'(1), CFG_W'(8191));
    random_items(80, 1'b1, -1);
    drain();

    idle_on <= 1'b0;
    configure(CFG_W'(1), CFG_W'(0), CFG_W'(2));
    random_items(40, 1'b0, -1);
    drain();

    configure(CFG_W'(0), CFG_W'(20'hFFFFF), CFG_W'(3));
    random_items(20, 1'b0, -1);
    drain();

    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> rle_palette_window_decoder.f
rtl/core/rpwd_pkg.sv
rtl/core/rpwd_ctrl.sv
rtl/core/rpwd_dp.sv
rtl/core/rle_palette_window_decoder.sv
tb/rpwd_pixel_checker.sv
tb/rle_palette_window_decoder_tb.sv
